/* design/stb_pkg.sv */
// shared types and constants for the software timer bank
// no dependencies
package stb_pkg;

    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_START = 2'd1,
        FUNC_STOP  = 2'd2,
        FUNC_CHECK = 2'd3
    } t_func;

    localparam int ID_W       = 8;
    localparam int PERIOD_W   = 32;
    localparam int RUN_W      = 31;
    localparam logic [RUN_W-1:0] RUN_WRAP = 31'h7FFF_FFFF;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 32;

endpackage

/* design/stb_cell.sv */
// one timer cell of the rotating ring: count and expired mark
// depends on nothing; instantiated by soft_timer_bank
module stb_cell #(
    parameter int COUNT_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_shift,
    input  logic [COUNT_BITS-1:0] i_count,
    input  logic                  i_mark,
    output logic [COUNT_BITS-1:0] o_count,
    output logic                  o_mark
);

    logic [COUNT_BITS-1:0] r_count;
    logic                  r_mark;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_mark  <= 1'b0;
        end else if (i_shift) begin
            r_count <= i_count;
            r_mark  <= i_mark;
        end
    end

    assign o_count = r_count;
    assign o_mark  = r_mark;

endmodule

/* design/stb_head.sv */
// head update: applies the current operation to the timer at the ring head
// depends on stb_pkg
module stb_head #(
    parameter int COUNT_BITS = 32,
    parameter int IDX_W      = 4
) (
    input  stb_pkg::t_func                i_func,
    input  logic [stb_pkg::ID_W-1:0]      i_timer_id,
    input  logic [stb_pkg::PERIOD_W-1:0]  i_period,
    input  logic [IDX_W-1:0]              i_step,
    input  logic [COUNT_BITS-1:0]         i_count,
    input  logic                          i_mark,
    output logic [COUNT_BITS-1:0]         o_count,
    output logic                          o_mark,
    output logic                          o_hit
);

    logic                  sel;
    logic [COUNT_BITS-1:0] dec;

    assign sel = (i_timer_id == stb_pkg::ID_W'(i_step));
    assign dec = i_count - COUNT_BITS'(1);

    always_comb begin
        o_count = i_count;
        o_mark  = i_mark;
        o_hit   = 1'b0;
        unique case (i_func)
            stb_pkg::FUNC_TICK: begin
                if (!i_mark && (i_count != '0)) begin
                    o_count = dec;
                    o_mark  = (dec == '0);
                end
            end
            stb_pkg::FUNC_START: begin
                if (sel) begin
                    o_count = COUNT_BITS'(i_period);
                    o_mark  = 1'b0;
                end
            end
            stb_pkg::FUNC_STOP: begin
                if (sel) begin
                    o_count = '0;
                    o_mark  = 1'b0;
                end
            end
            stb_pkg::FUNC_CHECK: begin
                if (sel) begin
                    o_hit  = i_mark;
                    o_mark = 1'b0;
                end
            end
            default: begin
                o_count = i_count;
            end
        endcase
    end

endmodule

/* design/soft_timer_bank.sv */
// soft_timer_bank: one-shot countdown timers kept in a rotating ring of cells
// depends on stb_pkg, stb_cell, stb_head
// an accepted transaction sweeps the ring in ST_SWEEP, then ST_FINISH loads the result register
// a new transaction is accepted only in ST_IDLE, after the previous one has loaded its result
// the result register lets the next transaction enter while a result waits
// synchronous active-low reset clears all timers, marks and the run-time counter
module soft_timer_bank #(
    parameter int NUM_TIMERS = 16,
    parameter int COUNT_BITS = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [stb_pkg::IN_DATA_W-1:0]   i_s_tdata,  // timer_id, period
    input  logic [1:0]                      i_s_tuser,  // func
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [stb_pkg::OUT_DATA_W-1:0]  o_m_tdata   // expired, run_time
);

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SWEEP  = 3'b010,
        ST_FINISH = 3'b100
    } t_state;

    t_state                        r_state, n_state;
    logic [IDX_W-1:0]              r_step, n_step;
    stb_pkg::t_func                r_func;
    logic [stb_pkg::ID_W-1:0]      r_id;
    logic [stb_pkg::PERIOD_W-1:0]  r_period;
    logic                          r_hit, n_hit;
    logic [stb_pkg::RUN_W-1:0]     r_run, n_run;
    logic                          r_out_valid, n_out_valid;
    logic                          r_out_expired;
    logic [stb_pkg::RUN_W-1:0]     r_out_run;

    logic                          accept;
    logic                          shift;
    logic                          out_load;
    logic [stb_pkg::RUN_W-1:0]     run_inc;

    logic [COUNT_BITS-1:0]         cell_count [NUM_TIMERS];
    logic                          cell_mark  [NUM_TIMERS];
    logic [COUNT_BITS-1:0]         head_count;
    logic                          head_mark;
    logic                          head_hit;

    assign o_s_tready = (r_state == ST_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign shift      = (r_state == ST_SWEEP);
    assign out_load   = (r_state == ST_FINISH) && (!r_out_valid || i_m_tready);
    assign run_inc    = r_run + stb_pkg::RUN_W'(1);

    stb_head #(
        .COUNT_BITS (COUNT_BITS),
        .IDX_W      (IDX_W)
    ) u_head (
        .i_func     (r_func),
        .i_timer_id (r_id),
        .i_period   (r_period),
        .i_step     (r_step),
        .i_count    (cell_count[0]),
        .i_mark     (cell_mark[0]),
        .o_count    (head_count),
        .o_mark     (head_mark),
        .o_hit      (head_hit)
    );

    for (genvar k = 0; k < NUM_TIMERS; k++) begin : g_cell
        logic [COUNT_BITS-1:0] feed_count;
        logic                  feed_mark;
        if (k == NUM_TIMERS - 1) begin : g_tail
            assign feed_count = head_count;
            assign feed_mark  = head_mark;
        end else begin : g_mid
            assign feed_count = cell_count[k+1];
            assign feed_mark  = cell_mark[k+1];
        end
        stb_cell #(
            .COUNT_BITS (COUNT_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (shift),
            .i_count (feed_count),
            .i_mark  (feed_mark),
            .o_count (cell_count[k]),
            .o_mark  (cell_mark[k])
        );
    end

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_hit       = r_hit;
        n_run       = r_run;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_SWEEP;
                    n_step  = '0;
                    n_hit   = 1'b0;
                    if (stb_pkg::t_func'(i_s_tuser) == stb_pkg::FUNC_TICK) begin
                        n_run = (run_inc == stb_pkg::RUN_WRAP) ? '0 : run_inc;
                    end
                end
            end
            ST_SWEEP: begin
                n_hit  = r_hit | head_hit;
                n_step = r_step + IDX_W'(1);
                if (r_step == IDX_W'(NUM_TIMERS - 1)) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_load) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_hit       <= 1'b0;
            r_run       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_hit       <= n_hit;
            r_run       <= n_run;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func   <= stb_pkg::t_func'(i_s_tuser);
            r_id     <= i_s_tdata[stb_pkg::ID_W-1:0];
            r_period <= i_s_tdata[stb_pkg::ID_W +: stb_pkg::PERIOD_W];
        end
        if (out_load) begin
            r_out_expired <= r_hit;
            r_out_run     <= r_run;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_run, r_out_expired};

endmodule
